@@ sv/cnt_pkg.sv @@
// ----------------------------------------------------------------------------
// cnt_pkg: challenge nonce table shared types and constants
// Widths of the stored key, challenge and time fields, and the per-slot
// result of the slot evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cnt_pkg;

   localparam int KEY_W       = 256;
   localparam int CHAL_W      = 64;
   localparam int TIME_W      = 32;
   localparam int SLOT_USED_W = 3;

   localparam logic [TIME_W-1:0] LIFETIME_RESET = 32'd120000;

   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [CHAL_W-1:0] chal_type;
   typedef logic [TIME_W-1:0] time_type;

   typedef struct packed {
      logic     live;
      logic     key_hit;
      logic     chal_hit;
      time_type age;
   } eval_type;

endpackage

`default_nettype wire

@@ sv/cnt_ram.sv @@
// ----------------------------------------------------------------------------
// cnt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cnt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ sv/cnt_slot_eval.sv @@
// ----------------------------------------------------------------------------
// cnt_slot_eval: per-slot compare unit
// Computes the age of one slot, checks expiry against the lifetime and
// compares stored key and challenge with the request.
// ----------------------------------------------------------------------------
`default_nettype none

module cnt_slot_eval
   import cnt_pkg::*;
(
   input  wire logic     time_valid,
   input  wire time_type time_rd,
   input  wire key_type  key_rd,
   input  wire chal_type chal_rd,
   input  wire time_type now_ms,
   input  wire key_type  key,
   input  wire chal_type cmp,
   input  wire time_type lifetime,
   output eval_type      result
);

   time_type t;

   always_comb begin
      t               = time_valid ? time_rd : '0;
      result.age      = now_ms - t;
      result.live     = (t != '0) && !(result.age > lifetime);
      result.key_hit  = result.live && (key_rd == key);
      result.chal_hit = result.key_hit && (chal_rd == cmp);
   end

endmodule

`default_nettype wire

@@ sv/challenge_nonce_table_core.sv @@
// ----------------------------------------------------------------------------
// challenge_nonce_table_core: nonce cache with expiry and oldest replacement
// A request taken in idle steps through a read state and an evaluate state
// per slot via the registered-read slot RAMs, then a claim state; the result
// strobe is registered from the claim state. Busy stays high until the core
// is back in idle, so a new request waits for the last. The receiver cannot
// stall. Synchronous reset empties all slots at once through per-slot valid
// bits and restores the lifetime to 120000.
// ----------------------------------------------------------------------------
`default_nettype none

module challenge_nonce_table_core
   import cnt_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [TIME_W-1:0]       req_now_ms,
   input  wire logic [63:0]             req_key_word0,
   input  wire logic [63:0]             req_key_word1,
   input  wire logic [63:0]             req_key_word2,
   input  wire logic [63:0]             req_key_word3,
   input  wire logic [CHAL_W-1:0]       req_offered_challenge,
   input  wire logic [CHAL_W-1:0]       req_fresh_random,
   output logic                         rsp_valid,
   output logic                         rsp_challenge_valid,
   output logic [CHAL_W-1:0]            rsp_next_challenge,
   output logic [SLOT_USED_W-1:0]       rsp_slot_used,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [TIME_W-1:0]       csr_challenge_lifetime
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;
   localparam logic [1:0] ST_CLAIM = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   time_type         now_ff;
   key_type          key_ff;
   chal_type         cmp_ff, cmp_in;
   chal_type         fresh_ff;
   time_type         life_ff;
   logic [SLOTS-1:0] tvalid_ff, tvalid_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] used_ff, used_in;
   logic             key_found_ff, key_found_in;
   logic [IDX_W-1:0] key_slot_ff, key_slot_in;
   logic             empty_found_ff, empty_found_in;
   logic [IDX_W-1:0] empty_idx_ff, empty_idx_in;
   time_type         oldest_ff, oldest_in;
   logic [IDX_W-1:0] oldest_idx_ff, oldest_idx_in;
   logic             rsp_valid_ff;
   logic             rsp_hit_ff;
   chal_type         rsp_chal_ff;
   logic [SLOT_USED_W-1:0] rsp_used_ff;

   logic             accept;
   logic             last_slot;
   logic [IDX_W-1:0] claim_idx;
   logic [IDX_W-1:0] wr_addr;
   logic             key_we;
   logic             slot_we;
   key_type          key_rd;
   chal_type         chal_rd;
   time_type         time_rd;
   eval_type         ev;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign last_slot = (idx_ff == IDX_W'(SLOTS - 1));

   assign claim_idx = key_found_ff   ? key_slot_ff :
                      empty_found_ff ? empty_idx_ff : oldest_idx_ff;

   assign wr_addr = (state_ff == ST_CLAIM) ? claim_idx : idx_ff;
   assign key_we  = (state_ff == ST_CLAIM) && !hit_ff;
   assign slot_we = key_we || ((state_ff == ST_EVAL) && ev.chal_hit);

   cnt_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_addr (idx_ff),
      .rd_data (key_rd)
   );

   cnt_ram #(.WIDTH(CHAL_W), .DEPTH(SLOTS)) u_chal_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (wr_addr),
      .wr_data (fresh_ff),
      .rd_addr (idx_ff),
      .rd_data (chal_rd)
   );

   cnt_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_time_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (wr_addr),
      .wr_data (now_ff),
      .rd_addr (idx_ff),
      .rd_data (time_rd)
   );

   cnt_slot_eval u_eval (
      .time_valid (tvalid_ff[idx_ff]),
      .time_rd    (time_rd),
      .key_rd     (key_rd),
      .chal_rd    (chal_rd),
      .now_ms     (now_ff),
      .key        (key_ff),
      .cmp        (cmp_ff),
      .lifetime   (life_ff),
      .result     (ev)
   );

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      cmp_in         = cmp_ff;
      tvalid_in      = tvalid_ff;
      hit_in         = hit_ff;
      used_in        = used_ff;
      key_found_in   = key_found_ff;
      key_slot_in    = key_slot_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      oldest_in      = oldest_ff;
      oldest_idx_in  = oldest_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in       = ST_READ;
               idx_in         = '0;
               cmp_in         = req_offered_challenge;
               hit_in         = 1'b0;
               used_in        = '0;
               key_found_in   = 1'b0;
               key_slot_in    = '0;
               empty_found_in = 1'b0;
               empty_idx_in   = '0;
               oldest_in      = '0;
               oldest_idx_in  = '0;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!ev.live) begin
               tvalid_in[idx_ff] = 1'b0;
               if (!empty_found_ff) begin
                  empty_found_in = 1'b1;
                  empty_idx_in   = idx_ff;
               end
            end else if (ev.age > oldest_ff) begin
               oldest_in     = ev.age;
               oldest_idx_in = idx_ff;
            end
            if (ev.key_hit) begin
               key_found_in = 1'b1;
               key_slot_in  = idx_ff;
            end
            if (ev.chal_hit) begin
               hit_in            = 1'b1;
               used_in           = idx_ff;
               cmp_in            = fresh_ff;
               tvalid_in[idx_ff] = 1'b1;
            end
            if (last_slot) begin
               state_in = ST_CLAIM;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_CLAIM: begin
            if (!hit_ff) begin
               tvalid_in[claim_idx] = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tvalid_ff    <= '0;
         life_ff      <= LIFETIME_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tvalid_ff    <= tvalid_in;
         rsp_valid_ff <= (state_ff == ST_CLAIM);
         if (csr_valid && csr_ready) begin
            life_ff <= csr_challenge_lifetime;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      cmp_ff         <= cmp_in;
      hit_ff         <= hit_in;
      used_ff        <= used_in;
      key_found_ff   <= key_found_in;
      key_slot_ff    <= key_slot_in;
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      oldest_ff      <= oldest_in;
      oldest_idx_ff  <= oldest_idx_in;
      if (accept) begin
         now_ff   <= req_now_ms;
         key_ff   <= {req_key_word0, req_key_word1, req_key_word2, req_key_word3};
         fresh_ff <= req_fresh_random;
      end
      if (state_ff == ST_CLAIM) begin
         rsp_hit_ff  <= hit_ff;
         rsp_chal_ff <= fresh_ff;
         rsp_used_ff <= SLOT_USED_W'(hit_ff ? used_ff : claim_idx);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_challenge_valid = rsp_hit_ff;
   assign rsp_next_challenge  = rsp_chal_ff;
   assign rsp_slot_used       = rsp_used_ff;

`ifndef SYNTHESIS
   a_rsp_after_claim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_CLAIM))
      else $error("result beat without a claim step");

   a_start_enters_scan: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_READ) && (idx_ff == '0))
      else $error("accepted request did not start the scan at slot 0");

   a_no_claim_on_hit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CLAIM) && hit_ff) |-> !key_we)
      else $error("key written although the challenge matched");
`endif

endmodule

`default_nettype wire
